@@ sv/sai_pkg.sv @@
// ----------------------------------------------------------------------------
// sai_pkg
// Shared constants, codes and types of the sorted array insert/remove core.
// ----------------------------------------------------------------------------
`default_nettype none

package sai_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;                      // width of the count field
  localparam int CNT_W    = $clog2(CAPACITY + 1);   // internal count width
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int STATUS_W = 2;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd2;

  // Operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } sai_op_e;

  typedef struct packed {
    sai_op_e                    op;
    logic signed [VALUE_W-1:0]  new_value;
  } sai_ctrl_t;

  // Per-cell position flags
  typedef struct packed {
    logic occupied;   // cell index below the count
    logic past_pos;   // cell index at or above the removal position
  } sai_cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/sai_if.sv @@
// ----------------------------------------------------------------------------
// sai_in_if / sai_out_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface sai_in_if import sai_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [VALUE_W-1:0]  new_value;
  logic [POS_W-1:0]           position;

  modport source (output valid, command, new_value, position, input ready);
  modport sink   (input valid, command, new_value, position, output ready);
endinterface

interface sai_out_if import sai_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  removed_value;
  logic [COUNT_W-1:0]         count_after;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, removed_value, count_after, status, input ready);
  modport sink   (input valid, removed_value, count_after, status, output ready);
endinterface

`default_nettype wire

@@ sv/sai_cell.sv @@
// ----------------------------------------------------------------------------
// sai_cell
// One entry of the sorted row: compares against the new value and takes its
// entry from the new value or from a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module sai_cell import sai_pkg::*; (
  input  wire logic                       clk_i,
  input  wire sai_ctrl_t                  ctrl_i,
  input  wire sai_cell_ctrl_t             pos_i,
  input  wire logic                       gt_left_i,
  input  wire logic signed [VALUE_W-1:0]  left_i,
  input  wire logic signed [VALUE_W-1:0]  right_i,
  output logic signed [VALUE_W-1:0]       value_o,
  output logic                            gt_o
);

  logic signed [VALUE_W-1:0] value_q, value_d;

  // An empty cell acts as plus infinity
  assign gt_o    = !pos_i.occupied || (value_q > ctrl_i.new_value);
  assign value_o = value_q;

  // Next entry: shift up behind the insert slot, shift down past the hole
  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (gt_left_i) begin
          value_d = left_i;
        end else if (gt_o) begin
          value_d = ctrl_i.new_value;
        end
      end
      OP_REMOVE: begin
        if (pos_i.past_pos) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

@@ sv/sorted_array_insert_remove_core.sv @@
// ----------------------------------------------------------------------------
// sorted_array_insert_remove_core
// Sorted store of signed values kept in a row of cells; insert in order,
// remove by position, one result per item.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                   | handshake
//  in_i    | in  | command, new_value, position             | valid/ready
//  out_o   | out | removed_value, count_after, status       | valid/ready
//
//  One item per cycle while the output is not stalled: all cells compare and shift in the same cycle the
//  item is accepted, and the result is held in an output register.
//  The result is valid in the cycle after the item is accepted.
//  A new item is taken whenever the output register is empty or being read.
//  Reset clears the count and the output valid; entries are written before
//  they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_insert_remove_core import sai_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sai_in_if.sink     in_i,
  sai_out_if.source  out_o
);

  logic [CNT_W-1:0]           count_q, count_d;
  logic                       out_valid_q;
  logic signed [VALUE_W-1:0]  removed_q, removed_d;
  logic [CNT_W-1:0]           out_count_q;
  logic [STATUS_W-1:0]        status_q, status_d;

  logic                       accept;
  logic                       full;
  logic                       bad_pos;
  sai_ctrl_t                  ctrl;
  sai_cell_ctrl_t             cell_pos [CAPACITY];
  logic signed [VALUE_W-1:0]  cell_val [CAPACITY];
  logic                       cell_gt  [CAPACITY];
  logic signed [VALUE_W-1:0]  sel_val;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign full    = (count_q == CNT_W'(CAPACITY));
  assign bad_pos = (CMP_W'(in_i.position) >= CMP_W'(count_q));

  // Decode the item into a cell operation
  always_comb begin
    ctrl.new_value = in_i.new_value;
    ctrl.op        = OP_HOLD;
    count_d        = count_q;
    removed_d      = '0;
    status_d       = STATUS_DONE;
    if (in_i.command == CMD_INSERT) begin
      if (full) begin
        status_d = STATUS_FULL;
      end else begin
        ctrl.op = accept ? OP_INSERT : OP_HOLD;
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (bad_pos) begin
        status_d = STATUS_BAD_POS;
      end else begin
        ctrl.op   = accept ? OP_REMOVE : OP_HOLD;
        count_d   = count_q - CNT_W'(1);
        removed_d = sel_val;
      end
    end
  end

  // Entry at the removal position
  always_comb begin
    sel_val = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (CMP_W'(k) == CMP_W'(in_i.position)) begin
        sel_val = cell_val[k];
      end
    end
  end

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                       gt_left;
    logic signed [VALUE_W-1:0]  left_val;
    logic signed [VALUE_W-1:0]  right_val;

    assign cell_pos[g].occupied = (CMP_W'(g) < CMP_W'(count_q));
    assign cell_pos[g].past_pos = (CMP_W'(g) >= CMP_W'(in_i.position));

    if (g == 0) begin : g_first
      assign gt_left  = 1'b0;
      assign left_val = '0;
    end else begin : g_inner
      assign gt_left  = cell_gt[g-1];
      assign left_val = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[g];
    end else begin : g_body
      assign right_val = cell_val[g+1];
    end

    sai_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .pos_i     (cell_pos[g]),
      .gt_left_i (gt_left),
      .left_i    (left_val),
      .right_i   (right_val),
      .value_o   (cell_val[g]),
      .gt_o      (cell_gt[g])
    );
  end

  // Count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (in_i.ready) begin
        out_valid_q <= in_i.valid;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q   <= removed_d;
      out_count_q <= count_d;
      status_q    <= status_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.removed_value = removed_q;
  assign out_o.count_after   = COUNT_W'(out_count_q);
  assign out_o.status        = status_q;

endmodule

`default_nettype wire

@@ sv/sai_checker.sv @@
// ----------------------------------------------------------------------------
// sai_checker
// Port-level assertions for the sorted array insert/remove core.
// ----------------------------------------------------------------------------
`default_nettype none

module sai_checker import sai_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic signed [VALUE_W-1:0]  removed_value_i,
  input  wire logic [COUNT_W-1:0]         count_after_i,
  input  wire logic [STATUS_W-1:0]        status_i
);

  // Every accepted item has its result valid in the cycle after acceptance
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after accepted item");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(count_after_i)
      && $stable(status_i) && $stable(removed_value_i))
    else $error("stalled result changed");

  // Count never exceeds the store size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_after_i <= COUNT_W'(CAPACITY))
    else $error("count above capacity");

  // A refused insert only happens on a full store
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_FULL |-> count_after_i == COUNT_W'(CAPACITY)
      && removed_value_i == '0)
    else $error("full status with wrong count or value");

  // A refused remove never reports a removed value
  a_bad_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_BAD_POS |-> removed_value_i == '0)
    else $error("refused remove reported a value");

endmodule

bind sorted_array_insert_remove_core sai_checker u_sai_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .removed_value_i (out_o.removed_value),
  .count_after_i   (out_o.count_after),
  .status_i        (out_o.status)
);

`default_nettype wire
